// ----- hw/rtl/psalu_pkg.sv -----
// Shared types, operation codes and constants of the packed SIMD integer ALU.
`default_nettype none

package psalu_pkg;

  localparam int FUNC_W = 4;
  localparam int WORD_W = 32;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FN_ABS     = 4'd0;
  localparam logic [FUNC_W-1:0] FN_ABS2    = 4'd1;
  localparam logic [FUNC_W-1:0] FN_ADD2    = 4'd2;
  localparam logic [FUNC_W-1:0] FN_ADD4    = 4'd3;
  localparam logic [FUNC_W-1:0] FN_ADDSUB  = 4'd4;
  localparam logic [FUNC_W-1:0] FN_ADDSUB2 = 4'd5;
  localparam logic [FUNC_W-1:0] FN_AVG2    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_AVGU4   = 4'd7;
  localparam logic [FUNC_W-1:0] FN_CMPEQ2  = 4'd8;
  localparam logic [FUNC_W-1:0] FN_CMPEQ4  = 4'd9;
  localparam logic [FUNC_W-1:0] FN_CMPGT2  = 4'd10;
  localparam logic [FUNC_W-1:0] FN_CMPGTU4 = 4'd11;
  localparam logic [FUNC_W-1:0] FN_CMPLT2  = 4'd12;
  localparam logic [FUNC_W-1:0] FN_CMPLTU4 = 4'd13;
  localparam logic [FUNC_W-1:0] FN_SADD    = 4'd14;

  // Saturation limits.
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [15:0]       HALF_MIN = 16'h8000;
  localparam logic [15:0]       HALF_MAX = 16'h7fff;

  typedef struct packed {
    logic [WORD_W-1:0] src2;
    logic [WORD_W-1:0] src1;
    logic [FUNC_W-1:0] func;
  } psalu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_high;
    logic [WORD_W-1:0] result_low;
  } psalu_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/psalu_core.sv -----
// Combinational datapath of the packed SIMD integer ALU: word, halfword and byte lanes.
`default_nettype none

module psalu_core (
  input  psalu_pkg::psalu_req_t req,
  output psalu_pkg::psalu_res_t res
);
  import psalu_pkg::*;

  logic [31:0] a, b;
  logic [31:0] neg_a, sum32, dif32, abs_w, sat_w;
  logic        ovf;

  logic [31:0] h_sum, h_dif, h_abs, h_avg;
  logic [1:0]  h_eq, h_gt, h_lt;
  logic [31:0] b_sum, b_avg;
  logic [3:0]  b_eq, b_gt, b_lt;

  assign a = req.src1;
  assign b = req.src2;

  // Whole-word operations.
  assign neg_a = 32'd0 - a;
  assign sum32 = a + b;
  assign dif32 = a - b;
  assign abs_w = !a[31] ? a : ((a == WORD_MIN) ? WORD_MAX : neg_a);
  // Overflow when both operands share a sign and the sum does not.
  assign ovf   = ~(a[31] ^ b[31]) & (a[31] ^ sum32[31]);
  assign sat_w = ovf ? (a[31] ? WORD_MIN : WORD_MAX) : sum32;

  // Halfword lanes.
  always_comb begin
    logic [15:0] ha, hb;
    logic [16:0] hs;
    h_sum = '0;
    h_dif = '0;
    h_abs = '0;
    h_avg = '0;
    h_eq  = '0;
    h_gt  = '0;
    h_lt  = '0;
    for (int k = 0; k < 2; k++) begin
      ha = a[16*k +: 16];
      hb = b[16*k +: 16];
      h_sum[16*k +: 16] = ha + hb;
      h_dif[16*k +: 16] = ha - hb;
      h_abs[16*k +: 16] = !ha[15] ? ha : ((ha == HALF_MIN) ? HALF_MAX : 16'd0 - ha);
      // Sign-extended sum plus one, then an arithmetic halving keeps the floor.
      hs = {ha[15], ha} + {hb[15], hb} + 17'd1;
      h_avg[16*k +: 16] = hs[16:1];
      h_eq[k] = (ha == hb);
      h_gt[k] = ($signed(ha) > $signed(hb));
      h_lt[k] = ($signed(ha) < $signed(hb));
    end
  end

  // Byte lanes, all unsigned.
  always_comb begin
    logic [7:0] ba, bb;
    logic [8:0] bs;
    b_sum = '0;
    b_avg = '0;
    b_eq  = '0;
    b_gt  = '0;
    b_lt  = '0;
    for (int k = 0; k < 4; k++) begin
      ba = a[8*k +: 8];
      bb = b[8*k +: 8];
      b_sum[8*k +: 8] = ba + bb;
      bs = {1'b0, ba} + {1'b0, bb} + 9'd1;
      b_avg[8*k +: 8] = bs[8:1];
      b_eq[k] = (ba == bb);
      b_gt[k] = (ba > bb);
      b_lt[k] = (ba < bb);
    end
  end

  always_comb begin
    res = '0;
    case (req.func)
      FN_ABS:     res.result_low = abs_w;
      FN_ABS2:    res.result_low = h_abs;
      FN_ADD2:    res.result_low = h_sum;
      FN_ADD4:    res.result_low = b_sum;
      FN_ADDSUB: begin
        res.result_high = sum32;
        res.result_low  = dif32;
      end
      FN_ADDSUB2: begin
        res.result_high = h_sum;
        res.result_low  = h_dif;
      end
      FN_AVG2:    res.result_low = h_avg;
      FN_AVGU4:   res.result_low = b_avg;
      FN_CMPEQ2:  res.result_low = {30'd0, h_eq};
      FN_CMPEQ4:  res.result_low = {28'd0, b_eq};
      FN_CMPGT2:  res.result_low = {30'd0, h_gt};
      FN_CMPGTU4: res.result_low = {28'd0, b_gt};
      FN_CMPLT2:  res.result_low = {30'd0, h_lt};
      FN_CMPLTU4: res.result_low = {28'd0, b_lt};
      FN_SADD:    res.result_low = sat_w;
      default:    res = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/packed_simd_integer_alu.sv -----
// Top level of the packed SIMD integer ALU: input register, datapath and result register.
// A request passes through the input register and then the result register before its
// result is presented on the output channel. Throughput: one request per cycle while
// the output side does not stall; the single datapath sits between the two registers,
// and a stall holds the result register and a full input register in place.
// Reset clears the valid flags of both registers; the payload registers keep no reset.
`default_nettype none

module packed_simd_integer_alu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // func [3:0], src1 [35:4], src2 [67:36], zero [71:68]
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata   // result_low [31:0], result_high [63:32]
);
  import psalu_pkg::*;

  // Input register stage.
  logic       s1_valid_r, s1_valid_nxt;
  psalu_req_t req_r;
  logic       in_fire;
  logic       s1_adv;

  // Result register stage.
  logic       out_valid_r, out_valid_nxt;
  psalu_res_t res;
  psalu_res_t res_r;

  // The input stage moves forward whenever the result register is empty or is
  // being drained in this cycle. The input side may take a new request while the
  // input stage is empty or moving on, so a full pipeline streams every cycle while the output is ready.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load only on their own handshake events.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.func <= in_tdata[3:0];
      req_r.src1 <= in_tdata[35:4];
      req_r.src2 <= in_tdata[67:36];
    end
    if (s1_adv) begin
      res_r <= res;
    end
  end

  // All the arithmetic sits between the two registers.
  psalu_core u_core (
    .req (req_r),
    .res (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.result_high, res_r.result_low};

  // Only the two add/subtract forms may produce a nonzero high word.
  a_high_only_addsub: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (res.result_high != 32'd0)) |->
      (req_r.func == FN_ADDSUB || req_r.func == FN_ADDSUB2))
    else $error("high result word set by an operation other than addsub");

  // Halfword compare masks carry two lane bits only.
  a_cmp2_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (req_r.func == FN_CMPEQ2 || req_r.func == FN_CMPGT2 ||
                    req_r.func == FN_CMPLT2)) |-> (res.result_low[31:2] == 30'd0))
    else $error("halfword compare mask has bits above lane count");

  // Byte compare masks carry four lane bits only.
  a_cmp4_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (req_r.func == FN_CMPEQ4 || req_r.func == FN_CMPGTU4 ||
                    req_r.func == FN_CMPLTU4)) |-> (res.result_low[31:4] == 28'd0))
    else $error("byte compare mask has bits above lane count");

  // An accepted request always lands in the input stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted request lost at the input stage");

  // A request that leaves the input stage is shown on the output next cycle.
  a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_tvalid && res_r == $past(res)))
    else $error("advancing request not captured in the result register");

endmodule

`default_nettype wire

// ----- dv/psalu_result_checker.sv -----
// Checker for the packed SIMD integer ALU: predicts each result and compares it on the output.
module psalu_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,     // func [3:0], src1 [35:4], src2 [67:36], zero [71:68]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,    // result_low [31:0], result_high [63:32]
  output int          mismatch_count,
  output int          results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import psalu_pkg::*;

  psalu_res_t pending_results[$];
  psalu_req_t seen_request;
  psalu_res_t seen_result;
  psalu_res_t oldest_result;

  initial begin
    mismatch_count = 0;
    results_outstanding = 0;
  end

  // Lane-wise model of every operation. Lanes are halfwords (bits 16k+15..16k)
  // or bytes (bits 8k+7..8k); compare masks keep the bits above the lane count at zero.
  function automatic psalu_res_t alu_result_of(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    psalu_res_t r;
    logic [15:0] ha, hb;
    logic [7:0] ba, bb;
    logic signed [16:0] hsum;
    logic [8:0] bsum;
    logic [31:0] s;
    int k;
    r = '0;
    for (k = 0; k < 2; k++) begin
      ha = a[16*k +: 16];
      hb = b[16*k +: 16];
      case (op)
        FN_ABS2: begin
          if (ha == HALF_MIN) begin
            r.result_low[16*k +: 16] = HALF_MAX;
          end else begin
            r.result_low[16*k +: 16] = ha[15] ? -ha : ha;
          end
        end
        FN_ADD2: r.result_low[16*k +: 16] = ha + hb;
        FN_ADDSUB2: begin
          r.result_high[16*k +: 16] = ha + hb;
          r.result_low[16*k +: 16] = ha - hb;
        end
        FN_AVG2: begin
          // Sign-extended sum plus one, then an arithmetic halving (floor).
          hsum = $signed({ha[15], ha}) + $signed({hb[15], hb}) + 17'sd1;
          r.result_low[16*k +: 16] = hsum[16:1];
        end
        FN_CMPEQ2: r.result_low[k] = (ha == hb);
        FN_CMPGT2: r.result_low[k] = ($signed(ha) > $signed(hb));
        FN_CMPLT2: r.result_low[k] = ($signed(ha) < $signed(hb));
        default: ;
      endcase
    end
    for (k = 0; k < 4; k++) begin
      ba = a[8*k +: 8];
      bb = b[8*k +: 8];
      bsum = {1'b0, ba} + {1'b0, bb} + 9'd1;
      case (op)
        FN_ADD4: r.result_low[8*k +: 8] = ba + bb;
        FN_AVGU4: r.result_low[8*k +: 8] = bsum[8:1];
        FN_CMPEQ4: r.result_low[k] = (ba == bb);
        FN_CMPGTU4: r.result_low[k] = (ba > bb);
        FN_CMPLTU4: r.result_low[k] = (ba < bb);
        default: ;
      endcase
    end
    case (op)
      FN_ABS: begin
        if (a == WORD_MIN) begin
          r.result_low = WORD_MAX;
        end else begin
          r.result_low = a[31] ? -a : a;
        end
      end
      FN_ADDSUB: begin
        r.result_high = a + b;
        r.result_low = a - b;
      end
      FN_SADD: begin
        s = a + b;
        // Overflow only when both operands share a sign that the sum lost.
        if (a[31] == b[31] && s[31] != a[31]) begin
          s = a[31] ? WORD_MIN : WORD_MAX;
        end
        r.result_low = s;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen_request = in_tdata[67:0];
        pending_results.push_back(alu_result_of(seen_request.func, seen_request.src1,
                                                seen_request.src2));
      end
      if (out_tvalid && out_tready) begin
        seen_result = out_tdata;
        if (pending_results.size() == 0) begin
          $display("%0t: result %h arrived with no request outstanding", $time, out_tdata);
          mismatch_count++;
        end else begin
          oldest_result = pending_results.pop_front();
          if (seen_result.result_low !== oldest_result.result_low) begin
            $display("%0t: result_low expected %h, actual %h", $time,
                     oldest_result.result_low, seen_result.result_low);
            mismatch_count++;
          end
          if (seen_result.result_high !== oldest_result.result_high) begin
            $display("%0t: result_high expected %h, actual %h", $time,
                     oldest_result.result_high, seen_result.result_high);
            mismatch_count++;
          end
        end
      end
      results_outstanding <= pending_results.size();
    end
  end

endmodule

// ----- dv/packed_simd_integer_alu_tb.sv -----
// Testbench top for the packed SIMD integer ALU: clock, reset, request stimulus and verdict.
module packed_simd_integer_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psalu_pkg::*;

  // The one code the package leaves unnamed; the block must answer it with zeros.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 4'd15;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int QUIET_TAIL      = 200;
  localparam int CYCLE_LIMIT     = 250000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;     // func [3:0], src1 [35:4], src2 [67:36], zero [71:68]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // result_low [31:0], result_high [63:32]

  int mismatch_count;
  int results_outstanding;
  int cycle_count = 0;
  int tx_idle_odds = 0;   // 0 means the sender never idles; else one chance in this many
  int rx_stall_odds = 0;  // same for the receiver
  bit quiet_tail = 1'b0;  // set for the last stretch: no idling on either side

  always #10 clk = ~clk;

  packed_simd_integer_alu dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  psalu_result_checker u_result_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The receiver stalls in random bursts, except in the quiet tail.
  always begin
    @(posedge clk);
    if (!quiet_tail && rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  // Presents one request and returns at the edge where it is taken. The valid stays high
  // so that a following request can go out back to back; a gap lowers it first.
  task automatic issue_request(input logic [FUNC_W-1:0] op, input logic [31:0] a,
                               input logic [31:0] b);
    psalu_req_t req;
    req.func = op;
    req.src1 = a;
    req.src2 = b;
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (tx_idle_odds != 0 && $urandom_range(1, tx_idle_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Holds the sender off until every request sent so far has its result back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  // Operands lean toward the values where saturation, sign and carry behave specially:
  // whole-word limits, halfword limits per lane and byte limits per lane.
  function automatic logic [31:0] pick_operand();
    logic [31:0] w;
    int k;
    w = $urandom();
    case ($urandom_range(0, 7))
      4: begin
        case ($urandom_range(0, 5))
          0: w = 32'h0000_0000;
          1: w = 32'hffff_ffff;
          2: w = WORD_MIN;
          3: w = WORD_MAX;
          4: w = 32'h0000_0001;
          default: w = 32'hffff_0000;
        endcase
      end
      5: begin
        for (k = 0; k < 2; k++) begin
          case ($urandom_range(0, 4))
            0: w[16*k +: 16] = HALF_MIN;
            1: w[16*k +: 16] = HALF_MAX;
            2: w[16*k +: 16] = 16'h0000;
            3: w[16*k +: 16] = 16'hffff;
            default: w[16*k +: 16] = 16'h0001;
          endcase
        end
      end
      6: begin
        for (k = 0; k < 4; k++) begin
          case ($urandom_range(0, 5))
            0: w[8*k +: 8] = 8'h00;
            1: w[8*k +: 8] = 8'h01;
            2: w[8*k +: 8] = 8'h7f;
            3: w[8*k +: 8] = 8'h80;
            4: w[8*k +: 8] = 8'hfe;
            default: w[8*k +: 8] = 8'hff;
          endcase
        end
      end
      7: w = $urandom_range(0, 255);
      default: ;
    endcase
    return w;
  endfunction

  // The second operand often shares lanes with the first, or sits one bit away,
  // so that equal lanes and near misses show up in the compares.
  function automatic logic [31:0] pick_partner(input logic [31:0] a);
    logic [31:0] b;
    logic [31:0] keep;
    int k;
    keep = '0;
    case ($urandom_range(0, 7))
      5: b = a;
      6: begin
        for (k = 0; k < 4; k++) begin
          keep[8*k +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        b = (a & keep) | ($urandom() & ~keep);
      end
      7: b = a ^ (32'h1 << $urandom_range(0, 31));
      default: b = pick_operand();
    endcase
    return b;
  endfunction

  initial begin
    int n;
    logic [FUNC_W-1:0] op;
    logic [31:0] a;
    logic [31:0] b;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: the saturation points, wrap-around in every lane width,
    // rounding of both averages, every compare in both directions and the unused code.
    tx_idle_odds = 3;
    rx_stall_odds = 3;
    issue_request(FN_ABS,     32'h8000_0000, 32'h0000_0000);
    issue_request(FN_ABS,     32'hffff_ffff, 32'h1234_5678);
    issue_request(FN_ABS,     32'h7fff_ffff, 32'hffff_ffff);
    issue_request(FN_ABS,     32'h0000_0000, 32'hffff_ffff);
    issue_request(FN_ABS2,    32'h8000_7fff, 32'hffff_ffff);
    issue_request(FN_ABS2,    32'hffff_8001, 32'h0000_0000);
    issue_request(FN_ADD2,    32'hffff_ffff, 32'h0001_0001);
    issue_request(FN_ADD4,    32'hffff_ffff, 32'h0101_0101);
    issue_request(FN_ADDSUB,  32'h7fff_ffff, 32'hffff_ffff);
    issue_request(FN_ADDSUB2, 32'h8000_0000, 32'h0001_0001);
    issue_request(FN_AVG2,    32'h8000_8000, 32'h8000_8000);
    issue_request(FN_AVG2,    32'h7fff_7fff, 32'h7fff_7fff);
    issue_request(FN_AVG2,    32'hffff_0000, 32'h0000_fffe);
    issue_request(FN_AVGU4,   32'hffff_ffff, 32'hffff_ffff);
    issue_request(FN_AVGU4,   32'h00ff_0100, 32'h0100_ff00);
    issue_request(FN_CMPEQ2,  32'h1234_5678, 32'h1234_9999);
    issue_request(FN_CMPEQ4,  32'haa00_ff55, 32'haa01_ff54);
    issue_request(FN_CMPGT2,  32'h8000_7fff, 32'h7fff_8000);
    issue_request(FN_CMPGTU4, 32'hff00_807f, 32'h00ff_7f80);
    issue_request(FN_CMPLT2,  32'h8000_7fff, 32'h7fff_8000);
    issue_request(FN_CMPLTU4, 32'hff00_807f, 32'h00ff_7f80);
    issue_request(FN_SADD,    32'h7fff_ffff, 32'h0000_0001);
    issue_request(FN_SADD,    32'h8000_0000, 32'hffff_ffff);
    issue_request(FN_SADD,    32'h8000_0000, 32'h7fff_ffff);
    issue_request(FN_UNUSED,  32'hffff_ffff, 32'hffff_ffff);

    // The sender waits here until the pipeline has emptied completely.
    drain_results();

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - QUIET_TAIL) begin
        quiet_tail = 1'b1;
        tx_idle_odds = 0;
      end else if (!quiet_tail && n % 64 == 0) begin
        // Each segment picks its own idling mix, including none at all.
        case ($urandom_range(0, 2))
          0: tx_idle_odds = 0;
          1: tx_idle_odds = 2;
          default: tx_idle_odds = 6;
        endcase
        case ($urandom_range(0, 2))
          0: rx_stall_odds = 0;
          1: rx_stall_odds = 2;
          default: rx_stall_odds = 6;
        endcase
      end
      if (n % 500 == 250) begin
        drain_results();
      end
      op = FUNC_W'($urandom_range(0, 15));
      a = pick_operand();
      b = pick_partner(a);
      issue_request(op, a, b);
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- packed_simd_integer_alu.f -----
hw/rtl/psalu_pkg.sv
hw/rtl/psalu_core.sv
hw/rtl/packed_simd_integer_alu.sv
dv/psalu_result_checker.sv
dv/packed_simd_integer_alu_tb.sv
